[hw/rtl/folded_substring_search_top_assert.svh]
// Assertion macros used by the checker file of the substring search block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FOLDED_SUBSTRING_SEARCH_TOP_ASSERT_SVH
`define FOLDED_SUBSTRING_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define FSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fss checker: same-cycle property failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define FSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fss checker: next-cycle property failed");

`endif

[hw/rtl/fss_pkg.sv]
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants of the folded substring search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fss_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int BYTE_W     = 8;
  localparam int SLOT_W     = 5;
  localparam int LEN_W      = 6;
  localparam int RESULT_W   = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLASH_FOLD     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 8'd3;

  // Item opcodes.
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_HAYSTACK = 1'b1;

  // Characters used by the folding rules.
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CHAR_SLASH    = 8'h2F;

  // Control broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic win_shift;
    logic win_clear;
    logic pat_shift;
    logic case_fold;
    logic slash_fold;
  } cell_ctrl_t;

endpackage

[hw/rtl/fss_cell.sv]
// ----------------------------------------------------------------------------
// fss_cell
// One cell of the compare row: a window byte, an aligned pattern byte, compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_cell import fss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [BYTE_W-1:0] win_i,
  output logic [BYTE_W-1:0] win_o,
  input  logic [BYTE_W-1:0] pat_i,
  output logic [BYTE_W-1:0] pat_o,
  input  logic              load_i,
  input  logic [BYTE_W-1:0] load_byte_i,
  input  logic              lane_en_i,
  output logic              eq_o
);

  logic [BYTE_W-1:0] win_q;
  logic [BYTE_W-1:0] pat_q;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic cf, input logic sf);
    logic [BYTE_W-1:0] r;
    r = b;
    if (cf && (r inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) begin
      r = r + (CHAR_LOWER_A - CHAR_UPPER_A);
    end
    if (sf && (r == CHAR_BACKSLASH)) begin
      r = CHAR_SLASH;
    end
    return r;
  endfunction

  // The window byte is cleared at the end of every search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.win_clear) begin
      win_q <= '0;
    end else if (ctrl_i.win_shift) begin
      win_q <= win_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_shift) begin
      pat_q <= pat_i;
    end else if (load_i) begin
      pat_q <= load_byte_i;
    end
  end

  assign win_o = win_q;
  assign pat_o = pat_q;
  assign eq_o  = !lane_en_i ||
                 (fold_byte(win_q, ctrl_i.case_fold, ctrl_i.slash_fold) ==
                  fold_byte(pat_q, ctrl_i.case_fold, ctrl_i.slash_fold));

endmodule

[hw/rtl/folded_substring_search_top.sv]
// ----------------------------------------------------------------------------
// folded_substring_search_top
// Streaming first-occurrence substring search over a row of compare cells.
// ----------------------------------------------------------------------------
// Input items arrive on a valid/ready channel. A load item writes one pattern
// byte into the slot it names. A haystack item first shifts its byte into the
// window row; in its compare cycle every cell then compares its window byte
// with the pattern byte aligned to it and the row is reduced to a single match
// flag. No input transfer is taken in the compare cycle.
// A haystack transfer marked last produces one result (found, match_index)
// through the compare stage and the output register; the search state is
// then cleared. Writing a pattern_length from 1 to PATTERN_MAX re-aligns the
// pattern held in the row, one pattern byte per cycle, and no input transfer
// is taken meanwhile. Configuration writes are taken in every cycle.
// The result waits in an output register. Input transfers continue while it
// waits; only a further last byte holds its compare cycle until the receiver
// has taken the waiting result, and input ready stays low during that hold.
// Reset clears the registers, the window row, the position and the hit flag.
// The pattern store holds no defined value until it has been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module folded_substring_search_top import fss_pkg::*; #(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input item channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [BYTE_W-1:0]     byte_value_i,
  input  logic [SLOT_W-1:0]     pattern_slot_i,
  input  logic                  last_byte_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [RESULT_W-1:0]   match_index_o
);

  localparam int IDX_W = $clog2(PATTERN_MAX);
  localparam int CMP_W = (POSITION_BITS > CFG_DATA_W) ? POSITION_BITS : CFG_DATA_W;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [LEN_W-1:0]         LEN_ONE = LEN_W'(1);

  // Configuration registers.
  logic                  case_fold_q;
  logic                  slash_fold_q;
  logic [CFG_DATA_W-1:0] start_q;
  logic [LEN_W-1:0]      len_q;

  // Pattern store, written by slot and read in order during re-alignment.
  logic [BYTE_W-1:0]     pat_q [PATTERN_MAX];
  logic                  rb_q;
  logic [LEN_W-1:0]      cnt_q;

  // Stream state.
  logic [POSITION_BITS-1:0] pos_q;
  logic                     hit_q;
  logic [POSITION_BITS-1:0] hit_idx_q;

  // Compare stage.
  logic                     pend_q;
  logic                     cand_q;
  logic                     last_q;
  logic [POSITION_BITS-1:0] begin_q;

  // Output register.
  logic                  out_valid_q;
  logic                  found_q;
  logic [RESULT_W-1:0]   match_q;

  logic                     cfg_acc;
  logic                     in_acc;
  logic                     hay;
  logic                     load;
  logic                     sat;
  logic                     adv;
  logic                     len_ok;
  logic [POSITION_BITS-1:0] len_m1;
  logic [POSITION_BITS-1:0] begin_pos;
  logic                     cand_d;
  logic                     slot_ok;
  logic [LEN_W-1:0]         lane;
  logic                     lane_ok;
  logic [LEN_W-1:0]         new_len;
  logic [BYTE_W-1:0]        pat_rd;
  logic                     all_eq;
  logic                     out_free;
  logic                     b_go;
  logic                     new_hit;
  logic                     hit_now;
  logic [POSITION_BITS-1:0] idx_now;
  cell_ctrl_t               ctrl;

  logic [BYTE_W-1:0]      win_o [PATTERN_MAX];
  logic [BYTE_W-1:0]      pat_o [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !pend_q && !rb_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign hay         = in_acc && (opcode_i == OP_HAYSTACK);
  assign load        = in_acc && (opcode_i == OP_LOAD);

  // Once the position saturates, later bytes neither shift nor compare.
  assign sat    = &pos_q;
  assign adv    = hay && !sat;
  assign len_ok = (len_q != '0) && (32'(len_q) <= PATTERN_MAX);

  // A window is complete once pos + 1 >= len, that is pos >= len - 1.
  assign len_m1    = POSITION_BITS'(len_q) - POS_ONE;
  assign begin_pos = pos_q - len_m1;
  assign cand_d    = adv && len_ok && (pos_q >= len_m1) &&
                     (CMP_W'(begin_pos) >= CMP_W'(start_q));

  // A loaded byte for slot s belongs in the cell at len - 1 - s.
  assign slot_ok = 32'(pattern_slot_i) < PATTERN_MAX;
  assign lane    = len_q - LEN_ONE - LEN_W'(pattern_slot_i);
  assign lane_ok = load && slot_ok && len_ok && (LEN_W'(pattern_slot_i) < len_q);
  assign new_len = cfg_data_i[LEN_W-1:0];
  assign pat_rd  = pat_q[IDX_W'(cnt_q)];

  assign ctrl.win_shift  = adv;
  assign ctrl.win_clear  = b_go && last_q;
  assign ctrl.pat_shift  = rb_q;
  assign ctrl.case_fold  = case_fold_q;
  assign ctrl.slash_fold = slash_fold_q;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [BYTE_W-1:0] win_in;
    logic [BYTE_W-1:0] pat_in;
    if (k == 0) begin : g_head
      assign win_in = byte_value_i;
      assign pat_in = pat_rd;
    end else begin : g_body
      assign win_in = win_o[k-1];
      assign pat_in = pat_o[k-1];
    end
    fss_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .win_i       (win_in),
      .win_o       (win_o[k]),
      .pat_i       (pat_in),
      .pat_o       (pat_o[k]),
      .load_i      (lane_ok && (32'(lane) == k)),
      .load_byte_i (byte_value_i),
      .lane_en_i   (32'(len_q) > k),
      .eq_o        (eq[k])
    );
  end

  // Compare stage: a last byte waits here until the output register is free.
  assign all_eq   = &eq;
  assign out_free = !out_valid_q || out_ready_i;
  assign b_go     = pend_q && (!last_q || out_free);
  assign new_hit  = !hit_q && cand_q && all_eq;
  assign hit_now  = hit_q || new_hit;
  assign idx_now  = hit_q ? hit_idx_q : begin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_fold_q  <= 1'b0;
      slash_fold_q <= 1'b0;
      start_q      <= '0;
      len_q        <= '0;
      rb_q         <= 1'b0;
      cnt_q        <= '0;
      pos_q        <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      pend_q       <= 1'b0;
      cand_q       <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // Re-alignment of the pattern row after a length change.
      if (rb_q) begin
        cnt_q <= cnt_q + LEN_ONE;
        if ((cnt_q + LEN_ONE) == len_q) begin
          rb_q <= 1'b0;
        end
      end
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_CASE_FOLD:    case_fold_q  <= cfg_data_i[0];
          CFG_SLASH_FOLD:   slash_fold_q <= cfg_data_i[0];
          CFG_START_OFFSET: start_q      <= cfg_data_i;
          CFG_PATTERN_LENGTH: begin
            len_q <= new_len;
            cnt_q <= '0;
            rb_q  <= (new_len != '0) && (32'(new_len) <= PATTERN_MAX);
          end
          default: ;
        endcase
      end

      if (hay) begin
        pend_q <= 1'b1;
        cand_q <= cand_d;
        last_q <= last_byte_i;
      end else if (b_go) begin
        pend_q <= 1'b0;
      end

      if (b_go && last_q) begin
        pos_q     <= '0;
        hit_q     <= 1'b0;
        hit_idx_q <= '0;
      end else begin
        if (adv) begin
          pos_q <= pos_q + POS_ONE;
        end
        if (b_go && new_hit) begin
          hit_q     <= 1'b1;
          hit_idx_q <= begin_q;
        end
      end

      if (b_go && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && slot_ok) begin
      pat_q[IDX_W'(pattern_slot_i)] <= byte_value_i;
    end
    if (hay) begin
      begin_q <= begin_pos;
    end
    if (b_go && last_q) begin
      found_q <= hit_now;
      match_q <= hit_now ? RESULT_W'(idx_now) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_index_o = match_q;

endmodule

[hw/rtl/fss_checker.sv]
// ----------------------------------------------------------------------------
// fss_checker
// Port-level checks of the folded substring search block, bound to its top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "folded_substring_search_top_assert.svh"

module fss_checker import fss_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  opcode_i,
  input logic                  last_byte_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  found_o,
  input logic [RESULT_W-1:0]   match_index_o
);

  logic hay_acc;
  logic hay_last_acc;

  assign hay_acc      = in_valid_i && in_ready_o && (opcode_i == OP_HAYSTACK);
  assign hay_last_acc = hay_acc && last_byte_i;

  // The compare cycle of a haystack byte takes no new transfer.
  `FSS_ASSERT_NEXT(a_compare_blocks_input, hay_acc, !in_ready_o)
  // A fresh result always stems from an accepted last byte.
  `FSS_ASSERT_IMPL(a_result_after_last, $rose(out_valid_o), $past(hay_last_acc, 2))
  // A miss reports index zero.
  `FSS_ASSERT_IMPL(a_miss_index_zero, out_valid_o && !found_o, match_index_o == '0)
  // A stalled result holds.
  `FSS_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(found_o) && $stable(match_index_o))

endmodule

bind folded_substring_search_top fss_checker u_fss_checker (.*);

[tb/sv/tb_folded_substring_search_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_folded_substring_search_top
// Self-checking testbench for the folded substring search block.
// ----------------------------------------------------------------------------
// A clocked driver takes pattern loads and haystack bytes from a queue that
// the stimulus process fills, and a clocked monitor takes the search results.
// Every accepted input transfer is passed to a search tracker that keeps its
// own pattern, window, position and hit state. On each last byte it
// queues the result it expects. The monitor compares each result transfer
// with the oldest queued expectation, field by field. Registers are changed
// only when the block has gone quiet: after reset, and between phases.
// ----------------------------------------------------------------------------

module tb_folded_substring_search_top;
  import fss_pkg::*;

  localparam int          PATTERN_MAX   = 32;
  localparam int          POSITION_BITS = 32;
  localparam int          CLK_HALF      = 5;
  // Idle cycles before a register write, so that no compare is still in flight.
  localparam int          SETTLE_CYCLES = 4;
  localparam int          LONG_STALL    = 300;
  localparam int          IDLE_PERCENT  = 22;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic [31:0] POS_LAST      = 32'hFFFF_FFFF;

  // Characters next to the folding ranges, used to probe their boundaries.
  localparam logic [BYTE_W-1:0] CASE_GAP     = CHAR_LOWER_A - CHAR_UPPER_A;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = CHAR_LOWER_A + 8'd25;
  localparam logic [BYTE_W-1:0] CHAR_AT      = CHAR_UPPER_A - 8'd1;
  localparam logic [BYTE_W-1:0] CHAR_BRACKET = CHAR_UPPER_Z + 8'd1;
  localparam logic [BYTE_W-1:0] CHAR_GRAVE   = CHAR_LOWER_A - 8'd1;
  localparam logic [BYTE_W-1:0] CHAR_BRACE   = CHAR_LOWER_Z + 8'd1;

  typedef struct {
    logic              op;
    logic [BYTE_W-1:0] value;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } stream_item_t;

  typedef struct {
    logic                found;
    logic [RESULT_W-1:0] index;
  } search_outcome_t;

  // Ports of the block. Every input starts from a known value.
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic                  opcode_i       = OP_LOAD;
  logic [BYTE_W-1:0]     byte_value_i   = '0;
  logic [SLOT_W-1:0]     pattern_slot_i = '0;
  logic                  last_byte_i    = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic                  found_o;
  logic [RESULT_W-1:0]   match_index_o;

  // Search tracker state: pattern store, window of recent bytes (entry 0 is
  // the newest), position counter, latched hit and its own register copies.
  logic [BYTE_W-1:0] pattern_copy [PATTERN_MAX] = '{default: '0};
  logic [BYTE_W-1:0] recent_bytes [PATTERN_MAX] = '{default: '0};
  logic [31:0]       bytes_seen     = '0;
  logic              hit_latched    = 1'b0;
  logic [31:0]       hit_start      = '0;
  logic              fold_case      = 1'b0;
  logic              fold_slash     = 1'b0;
  logic [31:0]       earliest_start = '0;
  logic [LEN_W-1:0]  needle_len     = '0;

  // Stimulus bookkeeping: what has been queued for loading, and the length
  // in force, so that haystacks can carry planted copies of the pattern.
  logic [BYTE_W-1:0] planned_pattern [PATTERN_MAX] = '{default: '0};
  int                planned_len    = 0;
  int                items_queued   = 0;

  stream_item_t    pending_items [$];
  search_outcome_t outcomes_due [$];
  int              mismatches     = 0;
  int              cycle_count    = 0;
  logic            calm_mode      = 1'b0;
  int              stall_requests = 0;
  int              stalls_served  = 0;
  int              stall_left     = 0;

  folded_substring_search_top #(
    .PATTERN_MAX  (PATTERN_MAX),
    .POSITION_BITS(POSITION_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .byte_value_i  (byte_value_i),
    .pattern_slot_i(pattern_slot_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .match_index_o (match_index_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Search tracker
  // --------------------------------------------------------------------------

  // Both sides of every compare are folded with the settings in force.
  function automatic logic [BYTE_W-1:0] fold_char(logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (fold_case && r >= CHAR_UPPER_A && r <= CHAR_UPPER_Z) r = r + CASE_GAP;
    if (fold_slash && r == CHAR_BACKSLASH) r = CHAR_SLASH;
    return r;
  endfunction

  // The oldest of the newest len bytes lines up with pattern byte 0.
  function automatic logic window_holds_needle(int len);
    for (int j = 0; j < len; j++) begin
      if (fold_char(recent_bytes[len - 1 - j]) != fold_char(pattern_copy[j])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void follow_item(stream_item_t it);
    longint unsigned pos;
    longint unsigned start_at;
    int              len;
    search_outcome_t outcome;
    if (it.op == OP_LOAD) begin
      pattern_copy[it.slot] = it.value;
      return;
    end
    // Once the position counter has saturated, bytes are no longer shifted
    // in or compared; they can still close the search.
    if (bytes_seen != POS_LAST) begin
      pos = 64'(bytes_seen);
      len = int'(needle_len);
      for (int k = PATTERN_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
      recent_bytes[0] = it.value;
      bytes_seen      = bytes_seen + 32'd1;
      // An empty or oversized pattern never matches, and no window is looked
      // at before enough bytes have arrived to fill it.
      if (!hit_latched && len != 0 && len <= PATTERN_MAX && pos + 64'd1 >= 64'(len)) begin
        start_at = pos + 64'd1 - 64'(len);
        if (start_at >= 64'(earliest_start) && window_holds_needle(len)) begin
          hit_latched = 1'b1;
          hit_start   = start_at[31:0];
        end
      end
    end
    if (!it.last) return;
    outcome.found = hit_latched;
    outcome.index = hit_latched ? hit_start : '0;
    outcomes_due.push_back(outcome);
    recent_bytes = '{default: '0};
    bytes_seen   = '0;
    hit_latched  = 1'b0;
    hit_start    = '0;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  // An offered item is held until its transfer; only then may the next one
  // be taken from the queue, or valid dropped for an idle cycle.
  always @(posedge clk_i or negedge rst_ni) begin : item_driver
    stream_item_t taken;
    stream_item_t next_item;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      opcode_i       <= OP_LOAD;
      byte_value_i   <= '0;
      pattern_slot_i <= '0;
      last_byte_i    <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        taken.op    = opcode_i;
        taken.value = byte_value_i;
        taken.slot  = pattern_slot_i;
        taken.last  = last_byte_i;
        follow_item(taken);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 &&
            (calm_mode || $urandom_range(99) >= IDLE_PERCENT)) begin
          next_item = pending_items.pop_front();
          in_valid_i     <= 1'b1;
          opcode_i       <= next_item.op;
          byte_value_i   <= next_item.value;
          pattern_slot_i <= next_item.slot;
          last_byte_i    <= next_item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  // Checks each result transfer against the oldest expectation and drives
  // the receiver's ready. A long hold-off is started whenever the stimulus
  // raises the request count; it is timed here, cycle by cycle.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    search_outcome_t due;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (outcomes_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual found=%0b match_index=%0d",
                   $time, found_o, match_index_o);
        end else begin
          due = outcomes_due.pop_front();
          if (found_o !== due.found) begin
            mismatches++;
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, due.found, found_o);
          end
          if (match_index_o !== due.index) begin
            mismatches++;
            $display("%0t: match_index mismatch, expected %0d, actual %0d",
                     $time, due.index, match_index_o);
          end
        end
      end
      if (stalls_served != stall_requests) begin
        stalls_served <= stall_requests;
        stall_left    <= LONG_STALL;
        out_ready_i   <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm_mode || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: a run that hangs is a failed run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_item(logic op, logic [BYTE_W-1:0] value, logic [SLOT_W-1:0] slot,
                            logic last);
    stream_item_t it;
    it.op    = op;
    it.value = value;
    it.slot  = slot;
    it.last  = last;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // The last flag of a load is ignored, so it is random.
  task automatic queue_load(logic [SLOT_W-1:0] slot, logic [BYTE_W-1:0] value);
    planned_pattern[slot] = value;
    queue_item(OP_LOAD, value, slot, 1'($urandom_range(1)));
  endtask

  // Likewise the slot of a haystack byte.
  task automatic queue_byte(logic [BYTE_W-1:0] value, bit closing);
    queue_item(OP_HAYSTACK, value, SLOT_W'($urandom_range(PATTERN_MAX - 1)), closing);
  endtask

  task automatic queue_text(string text, bit closing);
    for (int i = 0; i < text.len(); i++) queue_byte(text[i], closing && i == text.len() - 1);
  endtask

  // Mostly characters on and around the folding ranges, so that folded and
  // unfolded matches are both common; now and then any byte at all.
  function automatic logic [BYTE_W-1:0] pick_char();
    if ($urandom_range(99) < 15) return BYTE_W'($urandom_range(255));
    case ($urandom_range(9))
      0:       return CHAR_UPPER_A;
      1:       return CHAR_UPPER_Z;
      2:       return CHAR_LOWER_A;
      3:       return CHAR_LOWER_Z;
      4:       return CHAR_AT;
      5:       return CHAR_BRACKET;
      6:       return CHAR_GRAVE;
      7:       return CHAR_BRACE;
      8:       return CHAR_BACKSLASH;
      default: return CHAR_SLASH;
    endcase
  endfunction

  // Swaps case or slash direction at random, so a swapped byte of a planted
  // copy matches only when the matching fold is switched on.
  function automatic logic [BYTE_W-1:0] disguise(logic [BYTE_W-1:0] b);
    if ($urandom_range(1) == 0) return b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return b + CASE_GAP;
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) return b - CASE_GAP;
    if (b == CHAR_SLASH) return CHAR_BACKSLASH;
    if (b == CHAR_BACKSLASH) return CHAR_SLASH;
    return b;
  endfunction

  // One haystack, usually with a copy of the current pattern planted in it.
  task automatic queue_search(int hay_len, bit closing);
    logic [BYTE_W-1:0] hay [$];
    int                plant_len;
    int                plant_at;
    plant_len = (planned_len > PATTERN_MAX) ? PATTERN_MAX : planned_len;
    for (int i = 0; i < hay_len; i++) hay.push_back(pick_char());
    if (plant_len != 0 && plant_len <= hay_len && $urandom_range(99) < 70) begin
      plant_at = $urandom_range(hay_len - plant_len);
      for (int j = 0; j < plant_len; j++) hay[plant_at + j] = disguise(planned_pattern[j]);
    end
    for (int i = 0; i < hay_len; i++) queue_byte(hay[i], closing && i == hay_len - 1);
  endtask

  // Returns once all queued items have been taken and every expected result
  // has arrived, and a haystack byte still in the row has been compared.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || outcomes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The tracker takes the new value at the transfer; nothing else is moving.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CASE_FOLD:      fold_case      = data[0];
      CFG_SLASH_FOLD:     fold_slash     = data[0];
      CFG_START_OFFSET:   earliest_start = data;
      CFG_PATTERN_LENGTH: needle_len     = data[LEN_W-1:0];
      default:            ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(bit cf, bit sf, logic [31:0] offset, int len);
    write_register(CFG_CASE_FOLD, CFG_DATA_W'(cf));
    write_register(CFG_SLASH_FOLD, CFG_DATA_W'(sf));
    write_register(CFG_START_OFFSET, offset);
    write_register(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
    planned_len = len;
  endtask

  // Mostly short patterns and small offsets so that matches are frequent,
  // with the empty, full and oversized lengths and far offsets mixed in.
  task automatic configure_random();
    logic [31:0] offset;
    int          len;
    int          r;
    r = $urandom_range(99);
    if (r < 60)      offset = $urandom_range(8);
    else if (r < 75) offset = '0;
    else if (r < 85) offset = 32'hFFFF_FFFF;
    else             offset = $urandom();
    r = $urandom_range(99);
    if (r < 50)      len = $urandom_range(2, 6);
    else if (r < 65) len = $urandom_range(7, 31);
    else if (r < 75) len = PATTERN_MAX;
    else if (r < 85) len = 0;
    else if (r < 93) len = $urandom_range(PATTERN_MAX + 1, 63);
    else             len = 1;
    configure(1'($urandom_range(1)), 1'($urandom_range(1)), offset, len);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int target;
    int r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole pattern store while the length is still zero, so no
    // compare can ever look at an entry that was never written.
    for (int s = 0; s < PATTERN_MAX; s++) begin
      queue_load(SLOT_W'(s), BYTE_W'($urandom_range(255)));
    end

    // Empty pattern: with the registers as reset, nothing may match.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_text("A", 1'b1);
    wait_idle();

    // Both folds on: "a/Z" then 0xFF matches the pattern "A\z" then 0xFF at
    // index 1. A following search of two bytes is too short to compare.
    configure(1'b1, 1'b1, '0, 4);
    queue_load(SLOT_W'(0), CHAR_UPPER_A);
    queue_load(SLOT_W'(1), CHAR_BACKSLASH);
    queue_load(SLOT_W'(2), CHAR_LOWER_Z);
    queue_load(SLOT_W'(3), 8'hFF);
    queue_byte(8'h00, 1'b0);
    queue_text("a/Z", 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_text("[@", 1'b1);
    wait_idle();

    // Folds off: only the exact copy further on may match.
    configure(1'b0, 1'b0, '0, 4);
    queue_text("a/Z", 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_text("A\\z", 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // Oversized length: the same exact copy must not match.
    configure(1'b0, 1'b0, '0, 63);
    queue_text("A\\z", 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // Full length with the farthest offset.
    configure(1'b1, 1'b0, 32'hFFFF_FFFF, PATTERN_MAX);
    queue_text("A", 1'b1);
    wait_idle();

    // One-byte pattern: earlier matches lie before the offset.
    configure(1'b1, 1'b0, 2, 1);
    queue_text("aAbA", 1'b1);

    // Random phases. A phase may end inside an open haystack, so the next
    // register settings then apply to the rest of that search. Each phase
    // ends with the sender holding back until every result is in.
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      calm_mode <= (phase == 3);
      configure_random();
      if ($urandom_range(1) == 0) begin
        for (int s = 0; s < planned_len && s < PATTERN_MAX; s++) queue_load(SLOT_W'(s), pick_char());
      end
      target = items_queued + 70;
      while (items_queued < target) begin
        r = $urandom_range(99);
        if (r < 8) begin
          // Pattern change in the middle of a search.
          queue_load(SLOT_W'($urandom_range(PATTERN_MAX - 1)), pick_char());
        end else if (r < 12) begin
          queue_byte(BYTE_W'($urandom_range(255)), $urandom_range(3) == 0);
        end else begin
          queue_search($urandom_range(1, ($urandom_range(9) == 0) ? 80 : 36),
                       $urandom_range(9) != 0);
        end
      end
    end

    // Back-pressure: the receiver holds off for a long stretch while many
    // short searches are offered, so one result waits in the output register
    // and the next last byte stalls the input.
    wait_idle();
    configure(1'b1, 1'b1, '0, 2);
    stall_requests <= stall_requests + 1;
    for (int n = 0; n < 60; n++) queue_search($urandom_range(1, 3), 1'b1);

    wait_idle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fss_pkg.sv
hw/rtl/fss_cell.sv
hw/rtl/folded_substring_search_top.sv
hw/rtl/fss_checker.sv
tb/sv/tb_folded_substring_search_top.sv
